// ===== rtl/core/mup_pkg.sv =====
// Shared types and constants of the MIDI to USB-MIDI packer.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mup_pkg;

  localparam int BYTE_W = 8;
  localparam int CIN_W  = 4;
  localparam int CNT_W  = 6;
  localparam int STAT_W = 3;

  localparam logic [CNT_W-1:0] MAX_PKT_RESET   = 6'd20;
  localparam int               QUEUE_DEPTH_DEF = 4;

  localparam logic [BYTE_W-1:0] SYSEX_START = 8'hF0;
  localparam logic [BYTE_W-1:0] SYSEX_END   = 8'hF7;
  localparam logic [BYTE_W-1:0] RT_FIRST    = 8'hF8;

  localparam logic [CIN_W-1:0] CIN_SYSEX_CONT = 4'h4;
  localparam logic [CIN_W-1:0] CIN_SYSEX_END1 = 4'h5;
  localparam logic [CIN_W-1:0] CIN_SYSEX_END2 = 4'h6;
  localparam logic [CIN_W-1:0] CIN_SYSEX_END3 = 4'h7;
  localparam logic [CIN_W-1:0] CIN_SINGLE     = 4'hF;

  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
  localparam logic [3:0] NIB_POLY_AT  = 4'hA;
  localparam logic [3:0] NIB_CTRL     = 4'hB;
  localparam logic [3:0] NIB_PROG     = 4'hC;
  localparam logic [3:0] NIB_CHAN_AT  = 4'hD;
  localparam logic [3:0] NIB_PITCH    = 4'hE;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_SYSEX = 2'd1,
    MODE_CHAN  = 2'd2
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_OVF     = 3'd1,
    ST_UNTERM  = 3'd2,
    ST_TRUNC   = 3'd3,
    ST_STRAY   = 3'd4
  } stat_t;

  // Work handed from the front to the back for one accepted byte.
  typedef struct packed {
    logic              has_pkt;
    logic [CIN_W-1:0]  cin;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [CNT_W-1:0]  slot;
    logic              has_sum;
    stat_t             sum_status;
    logic [CNT_W-1:0]  sum_total;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/midi_to_usb_midi_packer_top.sv =====
// Top level of the MIDI to USB-MIDI event packet packer.
// Instantiates mup_front, mup_queue and mup_back; depends on mup_pkg.
//
//   channel   direction  handshake            payload
//   in_       into block push / full          data_byte, end_of_stream
//   out_      out        empty / pop          result word (nine fields)
//   cfg_      into block valid / ready        max_packets
//
// One byte is taken per clock while the job queue is not full; the front
// updates the stream state in the cycle of acceptance. A byte that ends a
// stream after a packet gives two result words, sent packet first. A result
// word passes the job queue and the back's registered output stage to reach
// the out_ ports. Reset is synchronous and returns the limit to 20. full
// rises only when the job queue holds QUEUE_DEPTH jobs.
`default_nettype none

module midi_to_usb_midi_packer_top
  import mup_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic [BYTE_W-1:0] in_data_byte,
  input  wire logic              in_end_of_stream,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic                   out_result_kind,
  output logic [CIN_W-1:0]       out_code_index,
  output logic [BYTE_W-1:0]      out_first_byte,
  output logic [BYTE_W-1:0]      out_second_byte,
  output logic [BYTE_W-1:0]      out_third_byte,
  output logic [CNT_W-1:0]       out_slot_number,
  output logic [STAT_W-1:0]      out_status,
  output logic [CNT_W-1:0]       out_packet_total,
  output logic                   out_last_of_run,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CNT_W-1:0]  cfg_max_packets
);

  logic    acc, job_push, q_pop;
  job_t    job, head;
  q_stat_t q_stat;

  assign cfg_ready = 1'b1;
  assign in_full   = q_stat.full;
  assign acc       = in_push && !q_stat.full;

  mup_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_max   (cfg_max_packets),
    .acc       (acc),
    .data_byte (in_data_byte),
    .eos       (in_end_of_stream),
    .job_push  (job_push),
    .job       (job)
  );

  mup_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (job_push),
    .wr_job (job),
    .pop    (q_pop),
    .head   (head),
    .stat   (q_stat)
  );

  mup_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_stat           (q_stat),
    .q_pop            (q_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_result_kind  (out_result_kind),
    .out_code_index   (out_code_index),
    .out_first_byte   (out_first_byte),
    .out_second_byte  (out_second_byte),
    .out_third_byte   (out_third_byte),
    .out_slot_number  (out_slot_number),
    .out_status       (out_status),
    .out_packet_total (out_packet_total),
    .out_last_of_run  (out_last_of_run)
  );

`ifndef SYNTH
  a_q_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("job queue reports full and empty together");

  a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_result_kind) |-> out_last_of_run)
    else $error("summary word is not the last of its run");

  a_pkt_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_result_kind) |-> (out_status == ST_OK && out_packet_total == '0))
    else $error("event packet carries summary fields");

  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop) |-> !q_stat.empty)
    else $error("back end pops an empty job queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/mup_front.sv =====
// Front end of the packer: holds the stream state, classifies each byte and
// builds one job per byte that yields any result. Depends on mup_pkg.
`default_nettype none

module mup_front
  import mup_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CNT_W-1:0]  cfg_max,
  input  wire logic              acc,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic              eos,
  output logic                   job_push,
  output job_t                   job
);

  logic [CNT_W-1:0]  max_r;
  mode_t             mode_r, mode_nxt;
  logic [1:0]        held_r, held_nxt;
  logic [BYTE_W-1:0] hf_r, hf_nxt;
  logic [BYTE_W-1:0] hs_r, hs_nxt;
  logic [1:0]        need_r, need_nxt;
  logic [CNT_W-1:0]  done_r, done_nxt;
  stat_t             err_r, err_nxt;

  logic              want, stray, ovf, send;
  logic [CIN_W-1:0]  cin;
  logic [BYTE_W-1:0] b0, b1, b2;
  logic [CNT_W-1:0]  done_step;
  stat_t             err_step, sum_st;

  always_comb begin
    mode_nxt = mode_r;
    held_nxt = held_r;
    hf_nxt   = hf_r;
    hs_nxt   = hs_r;
    need_nxt = need_r;
    want     = 1'b0;
    stray    = 1'b0;
    cin      = '0;
    b0       = '0;
    b1       = '0;
    b2       = '0;
    if (err_r == ST_OK) begin
      case (mode_r)
        MODE_SYSEX: begin
          if (data_byte == SYSEX_END) begin
            want = 1'b1;
            case (held_r)
              2'd0: begin
                cin = CIN_SYSEX_END1;
                b0  = data_byte;
              end
              2'd1: begin
                cin = CIN_SYSEX_END2;
                b0  = hf_r;
                b1  = data_byte;
              end
              default: begin
                cin = CIN_SYSEX_END3;
                b0  = hf_r;
                b1  = hs_r;
                b2  = data_byte;
              end
            endcase
            mode_nxt = MODE_IDLE;
            held_nxt = 2'd0;
          end else if (held_r >= 2'd2) begin
            want     = 1'b1;
            cin      = CIN_SYSEX_CONT;
            b0       = hf_r;
            b1       = hs_r;
            b2       = data_byte;
            held_nxt = 2'd0;
          end else if (held_r == 2'd1) begin
            hs_nxt   = data_byte;
            held_nxt = 2'd2;
          end else begin
            hf_nxt   = data_byte;
            held_nxt = 2'd1;
          end
        end
        MODE_CHAN: begin
          if (need_r >= 2'd2) begin
            hs_nxt   = data_byte;
            held_nxt = 2'd2;
            need_nxt = 2'd1;
          end else begin
            want = 1'b1;
            cin  = hf_r[7:4];
            b0   = hf_r;
            if (held_r >= 2'd2) begin
              b1 = hs_r;
              b2 = data_byte;
            end else begin
              b1 = data_byte;
            end
            mode_nxt = MODE_IDLE;
            held_nxt = 2'd0;
            need_nxt = 2'd0;
          end
        end
        default: begin
          // Idle, and the unused mode code behaves the same way.
          if (data_byte == SYSEX_START) begin
            mode_nxt = MODE_SYSEX;
            hf_nxt   = data_byte;
            held_nxt = 2'd1;
          end else begin
            case (data_byte[7:4])
              NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_AT, NIB_CTRL, NIB_PITCH: begin
                mode_nxt = MODE_CHAN;
                hf_nxt   = data_byte;
                held_nxt = 2'd1;
                need_nxt = 2'd2;
              end
              NIB_PROG, NIB_CHAN_AT: begin
                mode_nxt = MODE_CHAN;
                hf_nxt   = data_byte;
                held_nxt = 2'd1;
                need_nxt = 2'd1;
              end
              default: begin
                if (data_byte >= RT_FIRST) begin
                  mode_nxt = MODE_IDLE;
                  want     = 1'b1;
                  cin      = CIN_SINGLE;
                  b0       = data_byte;
                end else begin
                  stray = 1'b1;
                end
              end
            endcase
          end
        end
      endcase
    end
  end

  // A packet that would pass the limit is dropped and latches an overflow.
  assign ovf       = want && (done_r >= max_r);
  assign send      = want && !ovf;
  assign done_step = send ? done_r + CNT_W'(1) : done_r;

  always_comb begin
    if (ovf) begin
      err_step = ST_OVF;
    end else if (stray) begin
      err_step = ST_STRAY;
    end else begin
      err_step = err_r;
    end
    if (err_step != ST_OK) begin
      sum_st = err_step;
    end else begin
      case (mode_nxt)
        MODE_SYSEX: sum_st = ST_UNTERM;
        MODE_CHAN:  sum_st = ST_TRUNC;
        default:    sum_st = ST_OK;
      endcase
    end
  end

  always_comb begin
    done_nxt = done_step;
    err_nxt  = err_step;
  end

  assign job_push       = acc && (send || eos);
  assign job.has_pkt    = send;
  assign job.cin        = cin;
  assign job.b0         = b0;
  assign job.b1         = b1;
  assign job.b2         = b2;
  assign job.slot       = done_r;
  assign job.has_sum    = eos;
  assign job.sum_status = sum_st;
  assign job.sum_total  = done_step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r  <= MAX_PKT_RESET;
      mode_r <= MODE_IDLE;
      held_r <= 2'd0;
      hf_r   <= '0;
      hs_r   <= '0;
      need_r <= 2'd0;
      done_r <= '0;
      err_r  <= ST_OK;
    end else begin
      if (cfg_we) begin
        max_r <= cfg_max;
      end
      if (acc) begin
        if (eos) begin
          mode_r <= MODE_IDLE;
          held_r <= 2'd0;
          hf_r   <= '0;
          hs_r   <= '0;
          need_r <= 2'd0;
          done_r <= '0;
          err_r  <= ST_OK;
        end else begin
          mode_r <= mode_nxt;
          held_r <= held_nxt;
          hf_r   <= hf_nxt;
          hs_r   <= hs_nxt;
          need_r <= need_nxt;
          done_r <= done_nxt;
          err_r  <= err_nxt;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mup_queue.sv =====
// Short job queue between the front and back of the packer.
// Depends on mup_pkg for the job type.
`default_nettype none

module mup_queue
  import mup_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t wr_job,
  input  wire logic pop,
  output job_t      head,
  output q_stat_t   stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  job_t              slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0] count_r;
  logic              do_push, do_pop;

  assign stat.full  = (count_r == CNT_QW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_QW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mup_back.sv =====
// Back end of the packer: turns each queued job into one or two result
// words in a registered output stage. Depends on mup_pkg.
`default_nettype none

module mup_back
  import mup_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire job_t               head,
  input  wire q_stat_t            q_stat,
  output logic                    q_pop,
  input  wire logic               out_pop,
  output logic                    out_empty,
  output logic                    out_result_kind,
  output logic [CIN_W-1:0]        out_code_index,
  output logic [BYTE_W-1:0]       out_first_byte,
  output logic [BYTE_W-1:0]       out_second_byte,
  output logic [BYTE_W-1:0]       out_third_byte,
  output logic [CNT_W-1:0]        out_slot_number,
  output logic [STAT_W-1:0]       out_status,
  output logic [CNT_W-1:0]        out_packet_total,
  output logic                    out_last_of_run
);

  logic              valid_r, valid_nxt;
  logic              phase_r, phase_nxt;
  logic              ld, sel_sum, last;

  logic              kind_r;
  logic [CIN_W-1:0]  cin_r;
  logic [BYTE_W-1:0] b0_r, b1_r, b2_r;
  logic [CNT_W-1:0]  slot_r, total_r;
  logic [STAT_W-1:0] stat_r;
  logic              last_r;

  // A job with both a packet and a summary takes two loads; phase marks
  // that the packet half has already gone out.
  assign ld      = !q_stat.empty && (!valid_r || out_pop);
  assign sel_sum = !head.has_pkt || phase_r;
  assign last    = sel_sum || !head.has_sum;
  assign q_pop   = ld && last;

  always_comb begin
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    if (ld) begin
      valid_nxt = 1'b1;
      phase_nxt = !last;
    end else if (out_pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      last_r <= last;
      if (sel_sum) begin
        kind_r  <= 1'b1;
        cin_r   <= '0;
        b0_r    <= '0;
        b1_r    <= '0;
        b2_r    <= '0;
        slot_r  <= '0;
        stat_r  <= head.sum_status;
        total_r <= head.sum_total;
      end else begin
        kind_r  <= 1'b0;
        cin_r   <= head.cin;
        b0_r    <= head.b0;
        b1_r    <= head.b1;
        b2_r    <= head.b2;
        slot_r  <= head.slot;
        stat_r  <= ST_OK;
        total_r <= '0;
      end
    end
  end

  assign out_empty        = !valid_r;
  assign out_result_kind  = kind_r;
  assign out_code_index   = cin_r;
  assign out_first_byte   = b0_r;
  assign out_second_byte  = b1_r;
  assign out_third_byte   = b2_r;
  assign out_slot_number  = slot_r;
  assign out_status       = stat_r;
  assign out_packet_total = total_r;
  assign out_last_of_run  = last_r;

endmodule

`default_nettype wire
